// ----- sv/ctc_pkg.sv -----
// ----------------------------------------------------------------------------
// Character transliteration chain: shared types and constants
// Character and operation widths, operation codes and the table depth.
// ----------------------------------------------------------------------------
`default_nettype none

package ctc_pkg;

	localparam int CHAR_W      = 7;
	localparam int OP_W        = 2;
	localparam int TABLE_DEPTH = 2 ** CHAR_W;

	typedef logic [CHAR_W-1:0] char_t;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD      = 2'd0,
		OP_TRANSLATE = 2'd1,
		OP_FINISH    = 2'd2
	} op_t;

endpackage

`default_nettype wire

// ----- sv/ctc_in_if.sv -----
// ----------------------------------------------------------------------------
// Character transliteration chain: input channel
// Valid/ready channel that carries one operation word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctc_in_if;
	import ctc_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	char_t             from_char;
	char_t             to_char;
	char_t             source_char;

	modport source (output valid, output operation, output from_char, output to_char,
		output source_char, input ready);
	modport sink (input valid, input operation, input from_char, input to_char,
		input source_char, output ready);

endinterface

`default_nettype wire

// ----- sv/ctc_out_if.sv -----
// ----------------------------------------------------------------------------
// Character transliteration chain: result channel
// Valid/ready channel that carries one translated character or a marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctc_out_if;
	import ctc_pkg::*;

	logic   valid;
	logic   ready;
	char_t  out_char;
	logic   end_of_string;
	logic   cycle_error;

	modport source (output valid, output out_char, output end_of_string,
		output cycle_error, input ready);
	modport sink (input valid, input out_char, input end_of_string,
		input cycle_error, output ready);

endinterface

`default_nettype wire

// ----- sv/char_transliteration_chain_top.sv -----
// ----------------------------------------------------------------------------
// Character transliteration chain
// Mapping table in a synchronous memory; a translate walks the chain one table
// read per cycle until a character maps to itself or the lookup bound is hit.
// ----------------------------------------------------------------------------
// Usage: words enter on item (valid/ready). A load word stores a from/to pair
// and gives no result. A translate word gives one result word on result with
// the final character of the chain, none when the chain ends at character 0,
// or a word with cycle_error set when the chain has not settled after
// ALPHABET lookups. A finish word restores the identity mapping at once and
// gives a word with end_of_string set. Operation code 3 is dropped, and so
// is a load from character 0. A translate makes its table lookups one per
// cycle through the single read port of the table memory.
// One word is worked on at a time; the result sits in an output register and
// item stays ready while that register is drained in the same cycle.
// When result stalls, item is not ready until the pending result is taken.
// Reset clears all changed marks (identity mapping) and the output register;
// table contents need no reset since an entry is read only once it is marked.
// ----------------------------------------------------------------------------
`default_nettype none

module char_transliteration_chain_top #(
	parameter int ALPHABET = 128
) (
	input  wire       clk,
	input  wire       arst_n,
	ctc_in_if.sink    item,
	ctc_out_if.source result
);
	import ctc_pkg::*;

	localparam int STEP_W = $clog2(ALPHABET);

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	state_t                  state_q;
	char_t                   cur_q;
	logic [STEP_W-1:0]       steps_q;
	logic [TABLE_DEPTH-1:0]  changed_q;
	logic                    out_valid_q;
	char_t                   out_char_q;
	logic                    eos_q;
	logic                    cyc_q;

	char_t                   map_mem [TABLE_DEPTH];
	char_t                   rd_q;

	logic                    accept;
	logic                    mem_we;
	char_t                   rd_addr;
	char_t                   walk_next;
	logic                    settled;
	logic                    last_step;
	logic                    emit;

	assign item.ready = (state_q == ST_IDLE) && (!out_valid_q || result.ready);
	assign accept     = item.valid && item.ready;

	// Only marked entries hold a mapping; an unmarked one is the identity.
	assign walk_next = changed_q[cur_q] ? rd_q : cur_q;
	assign settled   = (walk_next == cur_q);
	assign last_step = (steps_q == STEP_W'(ALPHABET - 1));

	assign rd_addr = (state_q == ST_WALK) ? walk_next : item.source_char;
	assign mem_we  = accept && (item.operation == OP_LOAD) && (item.from_char != '0);

	// A result word is produced by a finish, or by a walk that ends on a
	// nonzero character or runs out of lookups.
	assign emit = (accept && (item.operation == OP_FINISH)) ||
		((state_q == ST_WALK) && (settled ? (cur_q != '0) : last_step));

	assign result.valid         = out_valid_q;
	assign result.out_char      = out_char_q;
	assign result.end_of_string = eos_q;
	assign result.cycle_error   = cyc_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[item.from_char] <= item.to_char;
		end
		rd_q <= map_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			steps_q     <= '0;
			changed_q   <= '0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			eos_q       <= 1'b0;
			cyc_q       <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.operation)
							OP_LOAD: begin
								if (item.from_char != '0) begin
									changed_q[item.from_char] <= 1'b1;
								end
							end
							OP_TRANSLATE: begin
								cur_q   <= item.source_char;
								steps_q <= '0;
								state_q <= ST_WALK;
							end
							OP_FINISH: begin
								changed_q   <= '0;
								out_char_q  <= '0;
								eos_q       <= 1'b1;
								cyc_q       <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					if (settled) begin
						state_q <= ST_IDLE;
						// A chain that ends at character 0 deletes the character.
						if (cur_q != '0) begin
							out_char_q  <= cur_q;
							eos_q       <= 1'b0;
							cyc_q       <= 1'b0;
						end
					end else if (last_step) begin
						state_q     <= ST_IDLE;
						out_char_q  <= '0;
						eos_q       <= 1'b0;
						cyc_q       <= 1'b1;
					end else begin
						cur_q   <= walk_next;
						steps_q <= steps_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (item.operation == OP_FINISH)
		|=> (changed_q == '0) && out_valid_q && eos_q && !cyc_q)
		else $error("finish did not restore the table or give an end marker");

	a_translate_walks: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (item.operation == OP_TRANSLATE)
		|=> (state_q == ST_WALK) && (steps_q == '0) && !out_valid_q)
		else $error("translate did not start a walk");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (eos_q || cyc_q) |-> (out_char_q == '0) && !(eos_q && cyc_q))
		else $error("marker word carries a character or both flags");

	a_walk_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> !item.ready)
		else $error("input taken during a walk");

	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !eos_q && !cyc_q |-> (out_char_q != '0))
		else $error("deleted character was emitted");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_char_transliteration_chain_top.sv -----
// ----------------------------------------------------------------------------
// Character transliteration chain: testbench
// Drives load, translate and finish words with random gaps on both channels,
// keeps its own copy of the mapping table, and checks every result word in
// order against what that copy predicts. Covers the special characters,
// chains, deletions, cycles, a chain of maximum length, a long result stall
// and random strings of mapping pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_char_transliteration_chain_top;
	import ctc_pkg::*;

	localparam int ALPHABET     = 128;
	localparam int MAX_GAP      = 17;
	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_WORDS = 470;
	localparam int HOLD_CYCLES  = 120;
	localparam int REPORT_MAX   = 10;

	// The one operation code that the block drops.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		char_t ch;
		logic  eos;
		logic  cyc;
	} result_word_t;

	logic clk = 1'b0;
	logic arst_n;

	ctc_in_if  item_if ();
	ctc_out_if result_if ();

	char_transliteration_chain_top #(
		.ALPHABET(ALPHABET)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_if),
		.result(result_if)
	);

	always #2 clk = ~clk;

	// Mirror of the block's table. An entry is read only while its changed
	// bit is set, so entries never written are never looked at.
	char_t        mirror_map [TABLE_DEPTH];
	bit           mirror_changed [TABLE_DEPTH];
	result_word_t due_words [$];

	int mismatch_count = 0;
	int words_sent     = 0;
	int hold_cycles    = 0;
	bit steady         = 1'b0;

	function automatic void track_word(input logic [OP_W-1:0] op, input char_t from_c,
			input char_t to_c, input char_t src_c);
		char_t        cur;
		char_t        nxt;
		bit           settled;
		result_word_t w;
		cur = src_c;
		settled = 1'b0;
		case (op)
			OP_LOAD: begin
				if (from_c != '0) begin
					mirror_map[from_c] = to_c;
					mirror_changed[from_c] = 1'b1;
				end
			end
			OP_TRANSLATE: begin
				for (int steps = 0; steps < ALPHABET && !settled; steps++) begin
					nxt = mirror_changed[cur] ? mirror_map[cur] : cur;
					if (nxt == cur)
						settled = 1'b1;
					else
						cur = nxt;
				end
				if (!settled) begin
					w = '{ch: '0, eos: 1'b0, cyc: 1'b1};
					due_words.push_back(w);
				end else if (cur != '0) begin
					w = '{ch: cur, eos: 1'b0, cyc: 1'b0};
					due_words.push_back(w);
				end
			end
			OP_FINISH: begin
				foreach (mirror_changed[i])
					mirror_changed[i] = 1'b0;
				w = '{ch: '0, eos: 1'b1, cyc: 1'b0};
				due_words.push_back(w);
			end
			default: ;
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_word(input logic [OP_W-1:0] op, input char_t from_c,
			input char_t to_c, input char_t src_c);
		int gap;
		gap = steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_if.valid       <= 1'b1;
		item_if.operation   <= op;
		item_if.from_char   <= from_c;
		item_if.to_char     <= to_c;
		item_if.source_char <= src_c;
		do @(posedge clk); while (item_if.ready !== 1'b1);
		track_word(op, from_c, to_c, src_c);
		if (op != OP_UNUSED && !(op == OP_LOAD && from_c == '0))
			words_sent++;
		@(negedge clk);
	endtask

	task automatic load_pair(input char_t from_c, input char_t to_c);
		send_word(OP_LOAD, from_c, to_c, char_t'($urandom));
	endtask

	task automatic translate_char(input char_t src_c);
		send_word(OP_TRANSLATE, char_t'($urandom), char_t'($urandom), src_c);
	endtask

	task automatic finish_string();
		send_word(OP_FINISH, char_t'($urandom), char_t'($urandom), char_t'($urandom));
	endtask

	task automatic test_identity();
		translate_char(7'd1);
		translate_char(7'd65);
		translate_char(7'd127);
		translate_char(7'd0);
		finish_string();
	endtask

	task automatic test_pairs();
		load_pair(7'd97, 7'd98);
		load_pair(7'd98, 7'd99);
		translate_char(7'd97);
		translate_char(7'd98);
		load_pair(7'd97, 7'd100);
		translate_char(7'd97);
		// Character zero cannot be remapped.
		load_pair(7'd0, 7'd5);
		translate_char(7'd0);
		load_pair(7'd120, 7'd0);
		translate_char(7'd120);
		load_pair(7'd127, 7'd127);
		translate_char(7'd127);
		send_word(OP_UNUSED, 7'd127, 7'd127, 7'd127);
		finish_string();
		translate_char(7'd97);
	endtask

	task automatic test_cycle();
		load_pair(7'd10, 7'd11);
		load_pair(7'd11, 7'd10);
		translate_char(7'd10);
		translate_char(7'd11);
		finish_string();
		translate_char(7'd10);
	endtask

	// A chain through every nonzero character takes all the lookups the
	// bound allows; closing it into a loop must then raise the cycle flag.
	task automatic test_long_chain();
		for (int k = 1; k < TABLE_DEPTH - 1; k++)
			load_pair(char_t'(k), char_t'(k + 1));
		translate_char(7'd1);
		load_pair(7'd127, 7'd0);
		translate_char(7'd1);
		load_pair(7'd127, 7'd1);
		translate_char(7'd64);
		finish_string();
	endtask

	// The receiver stops for a long stretch while words keep coming, so the
	// block fills and drops ready on its input.
	task automatic test_backpressure();
		steady = 1'b1;
		hold_cycles = HOLD_CYCLES;
		for (int k = 0; k < 24; k++) begin
			if (k % 4 == 0)
				load_pair(char_t'($urandom_range(1, 127)), char_t'($urandom));
			else
				translate_char(char_t'($urandom_range(1, 127)));
		end
		finish_string();
		steady = 1'b0;
	endtask

	task automatic test_random_strings();
		char_t pool [6];
		int    pool_size;
		int    start;
		char_t f;
		char_t t;
		start = words_sent;
		while (words_sent < start + RANDOM_WORDS) begin
			steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 5) == 0) begin
				send_word(OP_W'($urandom_range(0, 3)), char_t'($urandom),
					char_t'($urandom), char_t'($urandom));
				continue;
			end
			// A small pool of characters makes chains, deletions and loops likely.
			pool_size = $urandom_range(2, 6);
			for (int i = 0; i < pool_size; i++)
				pool[i] = ($urandom_range(0, 9) == 0) ? '0 : char_t'($urandom_range(1, 127));
			repeat ($urandom_range(1, 6)) begin
				f = ($urandom_range(0, 7) == 0) ? char_t'($urandom)
					: pool[$urandom_range(0, pool_size - 1)];
				case ($urandom_range(0, 7))
					0: t = '0;
					1: t = char_t'($urandom);
					default: t = pool[$urandom_range(0, pool_size - 1)];
				endcase
				load_pair(f, t);
			end
			repeat ($urandom_range(1, 8)) begin
				if ($urandom_range(0, 4) == 0)
					translate_char(char_t'($urandom));
				else
					translate_char(pool[$urandom_range(0, pool_size - 1)]);
			end
			if ($urandom_range(0, 5) != 0)
				finish_string();
		end
		steady = 1'b0;
	endtask

	task automatic flag_mismatch(input string what, input result_word_t want,
			input result_word_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("mismatch %0d (%s): expected char %0d eos %b cyc %b, got char %0d eos %b cyc %b",
				mismatch_count, what, want.ch, want.eos, want.cyc, got.ch, got.eos, got.cyc);
	endtask

	always @(posedge clk) begin : check_result
		result_word_t got;
		result_word_t want;
		if (arst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
			got = '{ch: result_if.out_char, eos: result_if.end_of_string,
				cyc: result_if.cycle_error};
			if (due_words.size() == 0) begin
				flag_mismatch("word with nothing expected", '0, got);
			end else begin
				want = due_words.pop_front();
				if (got.ch !== want.ch || got.eos !== want.eos || got.cyc !== want.cyc)
					flag_mismatch("wrong word", want, got);
			end
		end
	end

	initial begin : drain
		int wait_cycles;
		result_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_cycles > 0) begin
				wait_cycles = hold_cycles;
				hold_cycles = 0;
			end else begin
				wait_cycles = steady ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (wait_cycles > 0) begin
				result_if.ready <= 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (result_if.valid !== 1'b1);
			@(negedge clk);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((item_if.valid === 1'b1 && item_if.ready === 1'b1) ||
					(result_if.valid === 1'b1 && result_if.ready === 1'b1))
				idle = 0;
			else
				idle++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		item_if.valid       = 1'b0;
		item_if.operation   = OP_LOAD;
		item_if.from_char   = '0;
		item_if.to_char     = '0;
		item_if.source_char = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_identity();
		test_pairs();
		test_cycle();
		test_long_chain();
		test_backpressure();
		test_random_strings();

		item_if.valid <= 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
		// Let a word still being walked show up if the block would send one.
		repeat (ALPHABET + 20) @(posedge clk);

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
